[sv/pointer_keyed_chained_hash_map_assert.svh]
// ----------------------------------------------------------------------------
// pointer keyed hash map assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POINTER_KEYED_CHAINED_HASH_MAP_ASSERT_SVH
`define POINTER_KEYED_CHAINED_HASH_MAP_ASSERT_SVH

// same-cycle implication
`define PKM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pkm check failed");

// next-cycle implication
`define PKM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pkm check failed");

`endif

[sv/pkm_pkg.sv]
// ----------------------------------------------------------------------------
// pkm_pkg
// Request kinds and the result record shared by the map engine and top level.
// ----------------------------------------------------------------------------
package pkm_pkg;

  localparam logic [1:0] K_FIND   = 2'd0;
  localparam logic [1:0] K_INSERT = 2'd1;
  localparam logic [1:0] K_FOI    = 2'd2;
  localparam logic [1:0] K_CLEAR  = 2'd3;

  localparam int SLOT_OUT_W = 10;
  localparam int CFG_W      = 4;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  valid_slot;
    logic                  pool_full;
  } res_t;

endpackage

[sv/pkm_front.sv]
// ----------------------------------------------------------------------------
// pkm_front
// Takes request items, hashes the key to a bucket and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
module pkm_front #(
  parameter int MAX_INDEX_BITS = 10,
  parameter int KEY_BITS       = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                kind,
  input  logic [63:0]               key,
  input  logic [pkm_pkg::CFG_W-1:0] bucket_bits,
  output logic                      q_valid,
  input  logic                      q_pop,
  output logic [1:0]                q_kind,
  output logic [KEY_BITS-1:0]       q_key,
  output logic [MAX_INDEX_BITS-1:0] q_bkt
);

  localparam int NCHUNK = (KEY_BITS + MAX_INDEX_BITS - 1) / MAX_INDEX_BITS;

  logic [1:0]                kind_r [2];
  logic [KEY_BITS-1:0]       key_r  [2];
  logic [MAX_INDEX_BITS-1:0] bkt_r  [2];
  logic                      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0]       key_m;
  logic [NCHUNK*MAX_INDEX_BITS-1:0] key_ext;
  logic [MAX_INDEX_BITS-1:0] fold, mask, bkt;
  logic                      do_push, do_pop;

  assign key_m   = key[KEY_BITS-1:0];
  assign key_ext = {{(NCHUNK*MAX_INDEX_BITS-KEY_BITS){1'b0}}, key_m};

  // any bucket hash will do: xor-fold the key down to the widest index
  always_comb begin
    fold = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      fold = fold ^ key_ext[i*MAX_INDEX_BITS +: MAX_INDEX_BITS];
    end
    for (int j = 0; j < MAX_INDEX_BITS; j++) begin
      mask[j] = ({28'd0, bucket_bits} > 32'(j));
    end
    bkt = fold & mask;
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_kind  = kind_r[rp_r];
  assign q_key   = key_r[rp_r];
  assign q_bkt   = bkt_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      kind_r[wp_r] <= kind;
      key_r[wp_r]  <= key_m;
      bkt_r[wp_r]  <= bkt;
    end
  end

endmodule

[sv/pkm_engine.sv]
// ----------------------------------------------------------------------------
// pkm_engine
// Carries out queued requests against the bucket, key and link memories:
// chain walk, insert at the head, and the bucket clearing sweep.
// ----------------------------------------------------------------------------
module pkm_engine #(
  parameter int MAX_INDEX_BITS = 10,
  parameter int POOL_ENTRIES   = 1024,
  parameter int KEY_BITS       = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr_req,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic [1:0]                q_kind,
  input  logic [KEY_BITS-1:0]       q_key,
  input  logic [MAX_INDEX_BITS-1:0] q_bkt,
  output logic                      res_valid,
  input  logic                      res_take,
  output pkm_pkg::res_t             res
);

  localparam int BKT_DEPTH = 1 << MAX_INDEX_BITS;
  localparam int SLOT_W    = $clog2(POOL_ENTRIES);
  localparam int PTR_W     = $clog2(POOL_ENTRIES + 1);
  localparam int OW        = pkm_pkg::SLOT_OUT_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [PTR_W-1:0]    head_mem [BKT_DEPTH];
  logic [KEY_BITS-1:0] key_mem  [POOL_ENTRIES];
  logic [PTR_W-1:0]    next_mem [POOL_ENTRIES];

  logic [2:0]                state_r, state_nxt;
  logic [MAX_INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                      clr_resp_r, clr_resp_nxt;
  logic [PTR_W-1:0]          used_r, used_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic [KEY_BITS-1:0]       key_r, key_nxt;
  logic [MAX_INDEX_BITS-1:0] bkt_r, bkt_nxt;
  pkm_pkg::res_t             res_r, res_nxt;

  logic [PTR_W-1:0]          head_rd, next_rd;
  logic [KEY_BITS-1:0]       key_rd;
  logic                      head_we, head_re, slot_we, slot_re;
  logic [MAX_INDEX_BITS-1:0] head_wa, head_ra;
  logic [PTR_W-1:0]          head_wd;
  logic [SLOT_W-1:0]         slot_wa, slot_ra;
  logic                      do_ins, do_miss, do_hit, follow;
  logic [PTR_W-1:0]          flink, link_r, link_nxt, hit_idx;
  logic [SLOT_W+OW-1:0]      slot_ext;

  assign q_pop     = (state_r == S_IDLE) && q_valid && !clr_req;
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    clr_resp_nxt = clr_resp_r;
    used_nxt     = used_r;
    kind_nxt     = kind_r;
    key_nxt      = key_r;
    bkt_nxt      = bkt_r;
    res_nxt      = res_r;
    link_nxt     = link_r;
    head_we = 1'b0; head_wa = cnt_r; head_wd = '0;
    head_re = 1'b0; head_ra = q_bkt;
    slot_we = 1'b0; slot_wa = used_r[SLOT_W-1:0];
    slot_re = 1'b0; slot_ra = '0;
    do_ins = 1'b0; do_miss = 1'b0; do_hit = 1'b0; follow = 1'b0;
    flink = '0;
    hit_idx = link_r - PTR_W'(1);
    slot_ext = '0;

    case (state_r)
      S_CLR: begin
        head_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {MAX_INDEX_BITS{1'b1}}) begin
          res_nxt   = '0;
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          kind_nxt = q_kind;
          key_nxt  = q_key;
          bkt_nxt  = q_bkt;
          if (q_kind == pkm_pkg::K_CLEAR) begin
            used_nxt     = '0;
            cnt_nxt      = '0;
            clr_resp_nxt = 1'b1;
            state_nxt    = S_CLR;
          end else begin
            head_re   = 1'b1;
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (kind_r == pkm_pkg::K_INSERT) begin
          do_ins = 1'b1;
        end else if (head_rd == '0) begin
          do_ins  = (kind_r == pkm_pkg::K_FOI);
          do_miss = (kind_r != pkm_pkg::K_FOI);
        end else begin
          follow = 1'b1;
          flink  = head_rd;
        end
      end
      S_WALK: begin
        if (key_rd == key_r) begin
          do_hit = 1'b1;
        end else if (next_rd == '0) begin
          do_ins  = (kind_r == pkm_pkg::K_FOI);
          do_miss = (kind_r != pkm_pkg::K_FOI);
        end else begin
          follow = 1'b1;
          flink  = next_rd;
        end
      end
      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (follow) begin
      slot_re   = 1'b1;
      slot_ra   = SLOT_W'(flink - PTR_W'(1));
      link_nxt  = flink;
      state_nxt = S_WALK;
    end
    if (do_hit) begin
      slot_ext  = {{OW{1'b0}}, hit_idx[SLOT_W-1:0]};
      res_nxt   = '{hit: 1'b1, slot: slot_ext[OW-1:0], valid_slot: 1'b1, pool_full: 1'b0};
      state_nxt = S_RESP;
    end
    if (do_miss) begin
      res_nxt   = '0;
      state_nxt = S_RESP;
    end
    if (do_ins) begin
      state_nxt = S_RESP;
      if (used_r == PTR_W'(POOL_ENTRIES)) begin
        res_nxt = '{hit: 1'b0, slot: '0, valid_slot: 1'b0, pool_full: 1'b1};
      end else begin
        // new slot becomes the chain head, old head its successor
        slot_we  = 1'b1;
        head_we  = 1'b1;
        head_wa  = bkt_r;
        head_wd  = used_r + PTR_W'(1);
        used_nxt = used_r + PTR_W'(1);
        slot_ext = {{OW{1'b0}}, used_r[SLOT_W-1:0]};
        res_nxt  = '{hit: 1'b0, slot: slot_ext[OW-1:0], valid_slot: 1'b1, pool_full: 1'b0};
      end
    end

    // a register write empties the map
    if (clr_req) begin
      used_nxt     = '0;
      cnt_nxt      = '0;
      clr_resp_nxt = 1'b0;
      state_nxt    = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      cnt_r      <= '0;
      clr_resp_r <= 1'b0;
      used_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      clr_resp_r <= clr_resp_nxt;
      used_r     <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    bkt_r  <= bkt_nxt;
    res_r  <= res_nxt;
    link_r <= link_nxt;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_rd <= head_mem[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      key_mem[slot_wa]  <= key_r;
      next_mem[slot_wa] <= head_rd;
    end
    if (slot_re) begin
      key_rd  <= key_mem[slot_ra];
      next_rd <= next_mem[slot_ra];
    end
  end

endmodule

[sv/pointer_keyed_chained_hash_map.sv]
// ----------------------------------------------------------------------------
// pointer_keyed_chained_hash_map
// Chained hash map from pointer keys to allocation-order slot numbers.
// ----------------------------------------------------------------------------
// Find, insert, find-or-insert and clear requests are queued two deep and
// served one at a time. A lookup reads the bucket head, then reads the
// key/link memory once per chain entry visited, then hands over the result;
// a plain insert reads the bucket head and then writes the new entry, and the
// insert of a find-or-insert miss is done in the cycle that ends the walk.
// Clear, reset and any write of bucket_index_bits sweep all 2^MAX_INDEX_BITS
// entries of the bucket table, one entry per cycle, during which no new
// request is started.
module pointer_keyed_chained_hash_map #(
  parameter int MAX_INDEX_BITS = 10,
  parameter int POOL_ENTRIES   = 1024,
  parameter int KEY_BITS       = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                in_kind,
  input  logic [63:0]               in_key,
  output logic                      empty,
  input  logic                      pop,
  output logic                      out_hit,
  output logic [9:0]                out_slot,
  output logic                      out_valid_slot,
  output logic                      out_pool_full,
  input  logic                      cfg_we,
  input  logic [pkm_pkg::CFG_W-1:0] cfg_data
);

  `include "pointer_keyed_chained_hash_map_assert.svh"

  logic [pkm_pkg::CFG_W-1:0] bbits_r, bbits_nxt;
  logic                      q_valid, q_pop, res_valid;
  logic [1:0]                q_kind;
  logic [KEY_BITS-1:0]       q_key;
  logic [MAX_INDEX_BITS-1:0] q_bkt;
  pkm_pkg::res_t             res;

  // saturate the written value into 1..MAX_INDEX_BITS
  always_comb begin
    bbits_nxt = bbits_r;
    if (cfg_we) begin
      if (cfg_data == '0) begin
        bbits_nxt = pkm_pkg::CFG_W'(1);
      end else if ({28'd0, cfg_data} > MAX_INDEX_BITS) begin
        bbits_nxt = pkm_pkg::CFG_W'(MAX_INDEX_BITS);
      end else begin
        bbits_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bbits_r <= pkm_pkg::CFG_W'(MAX_INDEX_BITS);
    end else begin
      bbits_r <= bbits_nxt;
    end
  end

  pkm_front #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS),
    .KEY_BITS      (KEY_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .kind       (in_kind),
    .key        (in_key),
    .bucket_bits(bbits_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_kind     (q_kind),
    .q_key      (q_key),
    .q_bkt      (q_bkt)
  );

  pkm_engine #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS),
    .POOL_ENTRIES  (POOL_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_req  (cfg_we),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_kind   (q_kind),
    .q_key    (q_key),
    .q_bkt    (q_bkt),
    .res_valid(res_valid),
    .res_take (pop),
    .res      (res)
  );

  assign empty          = !res_valid;
  assign out_hit        = res.hit;
  assign out_slot       = res.slot;
  assign out_valid_slot = res.valid_slot;
  assign out_pool_full  = res.pool_full;

  `PKM_ASSERT_NOW(a_full_no_slot, !empty && out_pool_full, !out_valid_slot && !out_hit)
  `PKM_ASSERT_NOW(a_hit_valid, !empty && out_hit, out_valid_slot)
  `PKM_ASSERT_NOW(a_none_zero, !empty && !out_valid_slot, out_slot == 10'd0)
  `PKM_ASSERT_NEXT(a_hold, !empty && !pop && !cfg_we, !empty && $stable(out_slot))

endmodule
